// ===== sv/whc_pkg.sv =====
package whc_pkg;

    localparam logic [14:0] ANG_FULL = 15'd23040;
    localparam logic signed [16:0] KW_FULL = 17'sd23040;
    localparam logic signed [16:0] KW_HALF = 17'sd11520;
    localparam logic signed [16:0] KW_QUARTER = 17'sd5760;
    localparam logic [13:0] A_HALF = 14'd11520;
    localparam logic [13:0] A_QUARTER = 14'd5760;
    localparam logic [12:0] DRIFT_MAX = 13'd5760;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [2:0] CLS_TAIL = 3'd0;
    localparam logic [2:0] CLS_HEAD = 3'd1;
    localparam logic [2:0] CLS_LEFT_HEAD = 3'd2;
    localparam logic [2:0] CLS_LEFT_TAIL = 3'd3;
    localparam logic [2:0] CLS_RIGHT_TAIL = 3'd4;
    localparam logic [2:0] CLS_RIGHT_HEAD = 3'd5;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_LEFT = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_NO_GS = 2'd1;
    localparam logic [1:0] ERR_DRIFT = 2'd2;

    typedef struct packed {
        logic [14:0] desired_track;
        logic [15:0] leg_distance;
        logic [14:0] true_airspeed;
        logic [14:0] wind_from;
        logic [14:0] wind_speed;
    } t_in;

    typedef struct packed {
        logic [2:0]         wind_class;
        logic [1:0]         correction_side;
        logic [12:0]        drift_magnitude;
        logic signed [15:0] corrected_heading;
        logic [15:0]        ground_speed;
        logic [31:0]        leg_time;
        logic [1:0]         error_code;
    } t_out;

    typedef struct packed {
        logic [2:0]         cls;
        logic [1:0]         side;
        logic               kw_pos;
        logic [14:0]        trk;
        logic [15:0]        leg_dist;
        logic [14:0]        vr;
        logic [14:0]        u;
        logic               spec;
        logic               cneg;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] uc;
        logic [29:0]        us;
        logic [57:0]        vv;
        logic [59:0]        usq;
        logic               dneg;
        logic [57:0]        sq_v;
        logic [57:0]        sq_res;
        logic [30:0]        w;
        logic [1:0]         err;
        logic [15:0]        gs;
        logic               ovf;
        logic [37:0]        num;
        logic [31:0]        quo;
        logic signed [33:0] vx;
        logic signed [33:0] vy;
        logic signed [31:0] vz;
    } t_work;

    // arctan(2^-i) in 2^-22 degree
    function automatic logic signed [31:0] atan_ang(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0: v = 32'sd188743680;
            5'd1: v = 32'sd111421900;
            5'd2: v = 32'sd58872272;
            5'd3: v = 32'sd29884485;
            5'd4: v = 32'sd15000234;
            5'd5: v = 32'sd7507429;
            5'd6: v = 32'sd3754631;
            5'd7: v = 32'sd1877430;
            5'd8: v = 32'sd938729;
            5'd9: v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/whc_rot_step.sv =====
module whc_rot_step
    import whc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  t_work i_d,
    output t_work o_d
);

    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [31:0] w_ang;

    always_comb begin
        o_d = i_d;
        w_dx = i_d.cy >>> IDX;
        w_dy = i_d.cx >>> IDX;
        w_ang = atan_ang(5'(IDX));
        if (i_d.cz >= 0) begin
            o_d.cx = i_d.cx - w_dx;
            o_d.cy = i_d.cy + w_dy;
            o_d.cz = i_d.cz - w_ang;
        end else begin
            o_d.cx = i_d.cx + w_dx;
            o_d.cy = i_d.cy - w_dy;
            o_d.cz = i_d.cz + w_ang;
        end
    end

endmodule

// ===== sv/whc_sqrt_step.sv =====
module whc_sqrt_step
    import whc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  t_work i_d,
    output t_work o_d
);

    localparam int SH = 56 - 2 * IDX;

    logic [57:0] w_bit;
    logic [57:0] w_trial;

    always_comb begin
        o_d = i_d;
        w_bit = 58'(1) << SH;
        w_trial = i_d.sq_res + w_bit;
        if (i_d.sq_v >= w_trial) begin
            o_d.sq_v = i_d.sq_v - w_trial;
            o_d.sq_res = (i_d.sq_res >> 1) + w_bit;
        end else begin
            o_d.sq_res = i_d.sq_res >> 1;
        end
    end

endmodule

// ===== sv/whc_back_step.sv =====
module whc_back_step
    import whc_pkg::*;
#(
    parameter int IDX = 0,
    parameter bit DO_VEC = 1'b1
) (
    input  t_work i_d,
    output t_work o_d
);

    localparam int SH = 31 - IDX;

    logic [62:0]        w_trial;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [31:0] w_ang;

    always_comb begin
        o_d = i_d;
        // one quotient bit of the leg time division
        w_trial = 63'(i_d.w) << SH;
        if (63'(i_d.num) >= w_trial) begin
            o_d.num = i_d.num - w_trial[37:0];
            o_d.quo[SH] = 1'b1;
        end
        // one vectoring step of the drift angle, when DO_VEC is set
        w_dx = i_d.vy >>> IDX;
        w_dy = i_d.vx >>> IDX;
        w_ang = atan_ang(5'(IDX));
        if (DO_VEC) begin
            if (i_d.vy > 0) begin
                o_d.vx = i_d.vx + w_dx;
                o_d.vy = i_d.vy - w_dy;
                o_d.vz = i_d.vz + w_ang;
            end else begin
                o_d.vx = i_d.vx - w_dx;
                o_d.vy = i_d.vy + w_dy;
                o_d.vz = i_d.vz - w_ang;
            end
        end
    end

endmodule

// ===== sv/wind_triangle_heading_correction.sv =====
// Wind triangle solver: each beat gives track, leg distance, airspeed and wind, and one
// result beat returns wind class, correction side, drift, corrected heading, ground speed,
// leg time and an error code. One beat is accepted per cycle unless o_in_stall is high. The
// pipe is a chain of one-step stages: a sine/cosine CORDIC of CORDIC_STAGES stages, a
// 29-stage square root and a 32-stage divider that runs alongside the drift CORDIC, plus the
// setup stages and the output register. A two-entry output buffer lets the pipe keep moving
// while a result is held, until the next valid result fills the skid entry; then the pipe
// freezes until the sink takes a result.
module wind_triangle_heading_correction
    import whc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int P_MUL = CORDIC_STAGES + 1;
    localparam int P_SQR = CORDIC_STAGES + 2;
    localparam int P_SUB = CORDIC_STAGES + 3;
    localparam int P_SQ0 = CORDIC_STAGES + 4;
    localparam int P_W = CORDIC_STAGES + 33;
    localparam int P_G = CORDIC_STAGES + 34;
    localparam int P_BK0 = CORDIC_STAGES + 35;
    localparam int NP = CORDIC_STAGES + 67;

    t_work      r_pipe [NP];
    t_work      n_pipe [NP];
    logic [NP-1:0] r_vld;
    logic       w_en;

    t_work      n_front;
    t_work      n_mul;
    t_work      n_sqr;
    t_work      n_sub;
    t_work      n_w;
    t_work      n_g;
    t_out       n_fin;

    t_out       r_out;
    t_out       r_skid;
    logic       r_ov;
    logic       r_sv;

    assign w_en = !r_sv;
    assign o_in_stall = r_sv;

    // front: wrap angles, classify the wind
    logic [14:0]        f_trk;
    logic [14:0]        f_wdir;
    logic signed [16:0] f_kw0;
    logic signed [16:0] f_kw;
    logic signed [16:0] f_abs;
    logic [13:0]        f_a;
    logic [12:0]        f_ang;

    always_comb begin
        f_trk = (i_in_data.desired_track > ANG_FULL) ?
                i_in_data.desired_track - ANG_FULL : i_in_data.desired_track;
        f_wdir = (i_in_data.wind_from > ANG_FULL) ?
                 i_in_data.wind_from - ANG_FULL : i_in_data.wind_from;
        f_kw0 = $signed({2'b0, f_wdir}) - $signed({2'b0, f_trk});
        if (f_kw0 > KW_HALF) begin
            f_kw = f_kw0 - KW_FULL;
        end else if (f_kw0 < -KW_HALF) begin
            f_kw = f_kw0 + KW_FULL;
        end else begin
            f_kw = f_kw0;
        end
        f_abs = (f_kw < 0) ? -f_kw : f_kw;
        f_a = f_abs[13:0];
        f_ang = (f_a > A_QUARTER) ? 13'(A_HALF - f_a) : f_a[12:0];

        n_front = '0;
        if (f_kw == 0) begin
            n_front.cls = CLS_TAIL;
            n_front.side = SIDE_NONE;
        end else if (f_kw == KW_HALF || f_kw == -KW_HALF) begin
            n_front.cls = CLS_HEAD;
            n_front.side = SIDE_NONE;
        end else if (f_kw > KW_QUARTER) begin
            n_front.cls = CLS_LEFT_HEAD;
            n_front.side = SIDE_LEFT;
        end else if (f_kw > 0) begin
            n_front.cls = CLS_LEFT_TAIL;
            n_front.side = SIDE_LEFT;
        end else if (f_kw >= -KW_QUARTER) begin
            n_front.cls = CLS_RIGHT_TAIL;
            n_front.side = SIDE_RIGHT;
        end else begin
            n_front.cls = CLS_RIGHT_HEAD;
            n_front.side = SIDE_RIGHT;
        end
        n_front.kw_pos = (f_kw > 0);
        n_front.trk = f_trk;
        n_front.leg_dist = i_in_data.leg_distance;
        n_front.vr = i_in_data.true_airspeed;
        n_front.u = i_in_data.wind_speed;
        n_front.spec = (f_a == 14'd0) || (f_a == A_HALF);
        n_front.cneg = (f_a > A_QUARTER);
        n_front.cx = GAIN_Q30;
        n_front.cy = '0;
        n_front.cz = $signed({3'b0, f_ang, 16'b0});
    end

    assign n_pipe[0] = n_front;

    genvar gk;
    generate
        for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_rot
            whc_rot_step #(.IDX(gk)) u_rot (
                .i_d(r_pipe[gk]),
                .o_d(n_pipe[gk+1])
            );
        end
    endgenerate

    // clamp sin/cos, scale by wind speed
    logic [30:0]        m_c;
    logic [30:0]        m_s;
    logic signed [31:0] m_cs;
    logic signed [47:0] m_pc;
    logic signed [47:0] m_pcr;
    logic [45:0]        m_ps;
    logic [45:0]        m_psr;

    always_comb begin
        n_mul = r_pipe[P_MUL-1];
        if (r_pipe[P_MUL-1].cx < 0) begin
            m_c = '0;
        end else if (r_pipe[P_MUL-1].cx > ONE_Q30) begin
            m_c = 31'h4000_0000;
        end else begin
            m_c = r_pipe[P_MUL-1].cx[30:0];
        end
        if (r_pipe[P_MUL-1].cy < 0) begin
            m_s = '0;
        end else if (r_pipe[P_MUL-1].cy > ONE_Q30) begin
            m_s = 31'h4000_0000;
        end else begin
            m_s = r_pipe[P_MUL-1].cy[30:0];
        end
        if (r_pipe[P_MUL-1].spec) begin
            m_c = 31'h4000_0000;
            m_s = '0;
        end
        m_cs = r_pipe[P_MUL-1].cneg ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
        m_pc = $signed({33'b0, r_pipe[P_MUL-1].u}) * $signed({{16{m_cs[31]}}, m_cs});
        m_pcr = m_pc + 48'sd32768;
        m_ps = {31'b0, r_pipe[P_MUL-1].u} * {15'b0, m_s};
        m_psr = m_ps + 46'd32768;
        n_mul.uc = m_pcr[47:16];
        n_mul.us = m_psr[45:16];
    end

    assign n_pipe[P_MUL] = n_mul;

    logic [29:0] q_vr2;

    always_comb begin
        n_sqr = r_pipe[P_SQR-1];
        q_vr2 = {15'b0, r_pipe[P_SQR-1].vr} * {15'b0, r_pipe[P_SQR-1].vr};
        n_sqr.vv = {q_vr2, 28'b0};
        n_sqr.usq = {30'b0, r_pipe[P_SQR-1].us} * {30'b0, r_pipe[P_SQR-1].us};
    end

    assign n_pipe[P_SQR] = n_sqr;

    logic signed [60:0] s_d;

    always_comb begin
        n_sub = r_pipe[P_SUB-1];
        s_d = $signed({3'b0, r_pipe[P_SUB-1].vv}) - $signed({1'b0, r_pipe[P_SUB-1].usq});
        n_sub.dneg = (s_d < 0);
        n_sub.sq_v = s_d[57:0];
        n_sub.sq_res = '0;
    end

    assign n_pipe[P_SUB] = n_sub;

    generate
        for (gk = 0; gk < 29; gk++) begin : g_sqrt
            whc_sqrt_step #(.IDX(gk)) u_sqrt (
                .i_d(r_pipe[P_SQ0+gk-1]),
                .o_d(n_pipe[P_SQ0+gk])
            );
        end
    endgenerate

    // first positive root of the ground speed quadratic
    logic signed [32:0] x_wa;
    logic signed [32:0] x_wb;

    always_comb begin
        n_w = r_pipe[P_W-1];
        x_wa = $signed({r_pipe[P_W-1].uc[31], r_pipe[P_W-1].uc})
               - $signed({4'b0, r_pipe[P_W-1].sq_res[28:0]});
        x_wb = $signed({r_pipe[P_W-1].uc[31], r_pipe[P_W-1].uc})
               + $signed({4'b0, r_pipe[P_W-1].sq_res[28:0]});
        n_w.w = '0;
        n_w.err = ERR_OK;
        if (r_pipe[P_W-1].dneg) begin
            n_w.err = ERR_NO_GS;
        end else if (x_wa > 0) begin
            n_w.w = x_wa[30:0];
        end else if (x_wb > 0) begin
            n_w.w = x_wb[30:0];
        end else begin
            n_w.err = ERR_NO_GS;
        end
    end

    assign n_pipe[P_W] = n_w;

    logic [31:0] g_sum;

    always_comb begin
        n_g = r_pipe[P_G-1];
        g_sum = {1'b0, r_pipe[P_G-1].w} + 32'd8192;
        n_g.gs = (g_sum[31:14] > 18'h0FFFF) ? 16'hFFFF : g_sum[29:14];
        // quotient reaches 2^32 exactly when distance >= w * 2^10
        n_g.ovf = ({25'b0, r_pipe[P_G-1].leg_dist} >= {r_pipe[P_G-1].w, 10'b0});
        if (r_pipe[P_G-1].err == ERR_OK && r_pipe[P_G-1].side != SIDE_NONE
            && r_pipe[P_G-1].vr == 15'd0) begin
            n_g.err = ERR_DRIFT;
        end
        n_g.num = {r_pipe[P_G-1].leg_dist, 22'b0};
        n_g.quo = '0;
        n_g.vx = $signed({5'b0, r_pipe[P_G-1].sq_res[28:0]});
        n_g.vy = $signed({4'b0, r_pipe[P_G-1].us});
        n_g.vz = '0;
    end

    assign n_pipe[P_G] = n_g;

    generate
        for (gk = 0; gk < 32; gk++) begin : g_back
            whc_back_step #(.IDX(gk), .DO_VEC(gk < CORDIC_STAGES)) u_back (
                .i_d(r_pipe[P_BK0+gk-1]),
                .o_d(n_pipe[P_BK0+gk])
            );
        end
    endgenerate

    // output formatting
    logic signed [31:0] z_r;
    logic [12:0]        z_drift;
    logic [12:0]        z_dm;
    logic signed [16:0] z_hd;

    always_comb begin
        z_r = r_pipe[NP-1].vz + 32'sd32768;
        if (r_pipe[NP-1].vz <= 0) begin
            z_drift = '0;
        end else if (z_r[31:16] > {3'b0, DRIFT_MAX}) begin
            z_drift = DRIFT_MAX;
        end else begin
            z_drift = z_r[28:16];
        end
        z_dm = (r_pipe[NP-1].err == ERR_OK && r_pipe[NP-1].side != SIDE_NONE) ?
               z_drift : 13'd0;
        z_hd = r_pipe[NP-1].kw_pos ?
               $signed({2'b0, r_pipe[NP-1].trk}) - $signed({4'b0, z_dm}) :
               $signed({2'b0, r_pipe[NP-1].trk}) + $signed({4'b0, z_dm});
        n_fin.wind_class = r_pipe[NP-1].cls;
        n_fin.correction_side = r_pipe[NP-1].side;
        n_fin.drift_magnitude = z_dm;
        n_fin.corrected_heading = (r_pipe[NP-1].err == ERR_OK) ? z_hd[15:0] : 16'sd0;
        n_fin.ground_speed = (r_pipe[NP-1].err == ERR_NO_GS) ? 16'd0 : r_pipe[NP-1].gs;
        if (r_pipe[NP-1].err == ERR_NO_GS) begin
            n_fin.leg_time = '0;
        end else if (r_pipe[NP-1].ovf) begin
            n_fin.leg_time = '1;
        end else begin
            n_fin.leg_time = r_pipe[NP-1].quo;
        end
        n_fin.error_code = r_pipe[NP-1].err;
    end

    generate
        for (gk = 0; gk < NP; gk++) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pipe[gk] <= n_pipe[gk];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NP-2:0], i_in_valid};
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_out_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_vld[NP-1];
            end
        end else if (r_vld[NP-1] && w_en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_out_stall) begin
            r_out <= r_sv ? r_skid : n_fin;
        end else if (r_vld[NP-1] && w_en) begin
            r_skid <= n_fin;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry full while output register empty");

    a_no_gs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.error_code == ERR_NO_GS) |->
        (r_out.ground_speed == 16'd0 && r_out.leg_time == 32'd0))
        else $error("ground speed error with nonzero speed or time");

    a_err_no_drift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.error_code != ERR_OK) |->
        (r_out.drift_magnitude == 13'd0 && r_out.corrected_heading == 16'sd0))
        else $error("error beat carries drift or heading");

    a_no_side_no_drift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.correction_side == SIDE_NONE) |-> (r_out.drift_magnitude == 13'd0))
        else $error("drift without correction side");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import whc_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY = CORDIC_STAGES + 68;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    wind_triangle_heading_correction #(.CORDIC_STAGES(CORDIC_STAGES)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    // arctan(2^-i) in 2^-22 degree
    longint atan_steps [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    t_out solution_q [$];
    int   mismatch_count = 0;
    int   hold_cycles = 0;
    bit   quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > val) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (val >= res + bitv) begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void rotate_sincos(input longint ang, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = ang * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_steps[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_steps[i];
            end
        end
        if (x < 0) x = 0;
        if (x > 64'sd1073741824) x = 64'sd1073741824;
        if (y < 0) y = 0;
        if (y > 64'sd1073741824) y = 64'sd1073741824;
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_steps[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_steps[i];
            end
        end
        if (z <= 0) return 0;
        z = (z + 32768) >>> 16;
        return (z > 5760) ? 5760 : z;
    endfunction

    function automatic t_out solve_triangle(input t_in it);
        longint trk, vr, wdir, u, kw, a, cosv, sinv, uc, us, v, d, w, r;
        longint drift, head, gs, lt, leg_dist;
        logic [1:0] err;
        t_out o;
        o = '0;
        trk = it.desired_track;
        leg_dist = it.leg_distance;
        vr = it.true_airspeed;
        wdir = it.wind_from;
        u = it.wind_speed;
        drift = 0;
        head = 0;
        err = ERR_OK;
        if (trk > 23040) trk = trk - 23040;
        if (wdir > 23040) wdir = wdir - 23040;
        kw = wdir - trk;
        if (kw > 11520) kw = kw - 23040;
        else if (kw < -11520) kw = kw + 23040;

        if (kw == 0) begin
            o.wind_class = CLS_TAIL; o.correction_side = SIDE_NONE;
        end else if (kw == 11520 || kw == -11520) begin
            o.wind_class = CLS_HEAD; o.correction_side = SIDE_NONE;
        end else if (kw > 5760) begin
            o.wind_class = CLS_LEFT_HEAD; o.correction_side = SIDE_LEFT;
        end else if (kw > 0) begin
            o.wind_class = CLS_LEFT_TAIL; o.correction_side = SIDE_LEFT;
        end else if (kw >= -5760) begin
            o.wind_class = CLS_RIGHT_TAIL; o.correction_side = SIDE_RIGHT;
        end else begin
            o.wind_class = CLS_RIGHT_HEAD; o.correction_side = SIDE_RIGHT;
        end

        a = (kw < 0) ? -kw : kw;
        if (a == 0) begin
            cosv = 64'sd1073741824; sinv = 0;
        end else if (a == 11520) begin
            cosv = -64'sd1073741824; sinv = 0;
        end else if (a > 5760) begin
            rotate_sincos(11520 - a, cosv, sinv);
            cosv = -cosv;
        end else begin
            rotate_sincos(a, cosv, sinv);
        end

        uc = (u * cosv + 32768) >>> 16;
        us = (u * sinv + 32768) >>> 16;
        v = vr * 16384;
        d = v * v - us * us;
        w = 0;
        r = 0;
        if (d < 0) begin
            err = ERR_NO_GS;
        end else begin
            r = int_sqrt(d);
            if (uc - r > 0) w = uc - r;
            else if (uc + r > 0) w = uc + r;
            else err = ERR_NO_GS;
        end

        gs = 0;
        lt = 0;
        if (err == ERR_OK) begin
            gs = (w + 8192) >>> 14;
            if (gs > 65535) gs = 65535;
            lt = (leg_dist <<< 22) / w;
            if (lt > 64'sd4294967295) lt = 64'sd4294967295;
            if (o.correction_side != SIDE_NONE) begin
                if (vr == 0) err = ERR_DRIFT;
                else drift = vector_angle(r, us);
            end
            if (err == ERR_OK) head = (kw > 0) ? trk - drift : trk + drift;
            else drift = 0;
        end
        o.drift_magnitude = drift[12:0];
        o.corrected_heading = head[15:0];
        o.ground_speed = gs[15:0];
        o.leg_time = lt[31:0];
        o.error_code = err;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (solution_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = solution_q.pop_front();
                if (o_out_data.wind_class !== want.wind_class)
                    report_mismatch("wind_class", o_out_data.wind_class, want.wind_class);
                if (o_out_data.correction_side !== want.correction_side)
                    report_mismatch("correction_side", o_out_data.correction_side,
                                    want.correction_side);
                if (o_out_data.drift_magnitude !== want.drift_magnitude)
                    report_mismatch("drift_magnitude", o_out_data.drift_magnitude,
                                    want.drift_magnitude);
                if (o_out_data.corrected_heading !== want.corrected_heading)
                    report_mismatch("corrected_heading", o_out_data.corrected_heading,
                                    want.corrected_heading);
                if (o_out_data.ground_speed !== want.ground_speed)
                    report_mismatch("ground_speed", o_out_data.ground_speed,
                                    want.ground_speed);
                if (o_out_data.leg_time !== want.leg_time)
                    report_mismatch("leg_time", o_out_data.leg_time, want.leg_time);
                if (o_out_data.error_code !== want.error_code)
                    report_mismatch("error_code", o_out_data.error_code, want.error_code);
            end
        end
    end

    // sink stall: long hold-off when requested, else random bursts
    initial begin
        int burst;
        burst = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                burst = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_triangle(input t_in it);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        solution_q.push_back(solve_triangle(it));
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_in make_triangle(input int trk, input int dist_val, input int vr,
                                          input int wdir, input int u);
        t_in it;
        it.desired_track = trk[14:0];
        it.leg_distance = dist_val[15:0];
        it.true_airspeed = vr[14:0];
        it.wind_from = wdir[14:0];
        it.wind_speed = u[14:0];
        return it;
    endfunction

    function automatic t_in random_triangle();
        int trk, wdir, vr, u;
        logic [95:0] raw;
        t_in it;
        if ($urandom_range(0, 4) == 0) begin
            raw = {$urandom, $urandom, $urandom};
            it = raw[$bits(t_in)-1:0];
            return it;
        end
        trk = $urandom_range(0, 23040);
        vr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(800, 32767);
        u = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(0, vr);
        case ($urandom_range(0, 7))
            0: wdir = trk;
            1: wdir = trk + 11520;
            2: wdir = trk + 5760;
            3: wdir = trk - 5760;
            default: wdir = $urandom_range(0, 23040);
        endcase
        if (wdir < 0) wdir += 23040;
        if (wdir > 23040) wdir -= 23040;
        return make_triangle(trk, $urandom_range(0, 65535), vr, wdir, u);
    endfunction

    task automatic test_special_angles();
        send_triangle(make_triangle(0, 1600, 4000, 0, 800));          // tail wind
        send_triangle(make_triangle(4000, 1600, 4000, 15520, 800));   // head wind
        send_triangle(make_triangle(4000, 1600, 4000, 9760, 800));    // +90 tail-side
        send_triangle(make_triangle(9760, 1600, 4000, 4000, 800));    // -90 tail-side
        send_triangle(make_triangle(0, 1600, 4000, 12000, 900));      // right head-side
        send_triangle(make_triangle(0, 1600, 4000, 22000, 900));      // right tail-side
        send_triangle(make_triangle(0, 1600, 4000, 1000, 900));       // left tail-side
        send_triangle(make_triangle(12000, 1600, 4000, 1000, 900));   // right head-side
        send_triangle(make_triangle(23040, 65535, 32767, 0, 32767));
        send_triangle(make_triangle(32767, 0, 32767, 32767, 0));      // both above 360
        send_triangle(make_triangle(32767, 65535, 1, 23040, 1));
        send_triangle(make_triangle(100, 200, 1, 101, 0));
    endtask

    task automatic test_error_cases();
        send_triangle(make_triangle(0, 1600, 0, 5000, 800));          // zero airspeed, side wind
        send_triangle(make_triangle(0, 1600, 0, 0, 800));             // zero airspeed, tail wind
        send_triangle(make_triangle(0, 1600, 0, 0, 0));               // nothing moves
        send_triangle(make_triangle(0, 1600, 500, 11520, 800));       // head wind too strong
        send_triangle(make_triangle(0, 1600, 500, 6000, 32767));      // negative radicand
        send_triangle(make_triangle(0, 65535, 1, 11520, 1));          // ground speed near zero
        send_triangle(make_triangle(0, 65535, 2, 11520, 1));
        send_triangle(make_triangle(0, 65535, 32767, 23040, 32767));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_triangle(random_triangle());
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (solution_q.size() == 0);
        hold_cycles = 300;
        repeat (120) send_triangle(random_triangle());
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        repeat (150) send_triangle(random_triangle());
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_angles();
        test_error_cases();
        test_random_mix(300);
        test_backpressure();
        test_random_mix(150);
        test_quiet_tail();
        wait (solution_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
